[hdl/assert_macros.svh]
// Assertion macros shared by the grid cell corner point id block.
// Included by the modules that carry concurrent checks; no other dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
// Consequent must hold in the same cycle as the antecedent.
`define ASSERT_SAME_CYCLE(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("gcpid assertion failed");
// Consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT_CYCLE(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("gcpid assertion failed");
`else
`define ASSERT_SAME_CYCLE(label, clk, rst, ante, cons)
`define ASSERT_NEXT_CYCLE(label, clk, rst, ante, cons)
`endif
`endif

[hdl/gcpid_pkg.sv]
// Package of the grid cell corner point id block: widths, codes, corner order
// tables and the structs passed between its modules. No dependencies.
package gcpid_pkg;

   localparam int AXIS_BITS = 16;
   localparam int REG_W     = 32;
   localparam int ID_W      = 48;
   localparam int DIM_W     = AXIS_BITS;
   localparam int PLANE_W   = 2 * AXIS_BITS;
   localparam int CELLS_W   = 3 * AXIS_BITS;
   localparam int DELTA_W   = PLANE_W + 1;
   localparam int DIV_W     = (CELLS_W > ID_W) ? CELLS_W : ID_W;
   localparam int PID_W     = (CELLS_W + 1 > ID_W) ? CELLS_W + 1 : ID_W;
   localparam int CORNER_W  = 3;
   localparam int NCORNER   = 8;
   localparam int STATUS_W  = 2;
   localparam int CSR_IDX_W = 3;
   localparam int SETTLE_W  = 2;
   localparam logic [SETTLE_W-1:0] SETTLE_CYCLES = 2'd3;

   localparam int QDEPTH = 4;
   localparam int QPTR_W = 2;
   localparam int QCNT_W = 3;

   localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
   localparam logic [STATUS_W-1:0] ST_INVALID  = 2'd1;
   localparam logic [STATUS_W-1:0] ST_OVERFLOW = 2'd2;

   localparam logic [CSR_IDX_W-1:0] REG_X_LOW  = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_X_HIGH = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_Y_LOW  = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_Y_HIGH = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_Z_LOW  = 3'd4;
   localparam logic [CSR_IDX_W-1:0] REG_Z_HIGH = 3'd5;

   // Cyclic corner order for two and three active axes.
   localparam logic [CORNER_W-1:0] CYC2 [4] = '{3'd0, 3'd1, 3'd3, 3'd2};
   localparam logic [CORNER_W-1:0] CYC3 [8] =
      '{3'd0, 3'd1, 3'd3, 3'd2, 3'd4, 3'd5, 3'd7, 3'd6};

   typedef struct packed {
      logic [STATUS_W-1:0]               err;
      logic [DIM_W-1:0]                  dim0;
      logic [DIM_W-1:0]                  cdim0;
      logic [PLANE_W-1:0]                plane;
      logic [PLANE_W-1:0]                pplane;
      logic [CELLS_W-1:0]                cells;
      logic [CORNER_W-1:0]               last_corner;
      logic [NCORNER-1:0][DELTA_W-1:0]   delta;
   } cfg_type;

   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic [CELLS_W-1:0]  base;
   } qent_type;

endpackage

[hdl/gcpid_if.sv]
// Handshake channels of the grid cell corner point id block: request, response
// and register write. Depends on gcpid_pkg.
interface gcpid_req_if;
   import gcpid_pkg::*;
   logic            valid;
   logic            ready;
   logic [ID_W-1:0] cell_index;
   modport source (output valid, output cell_index, input ready);
   modport sink (input valid, input cell_index, output ready);
endinterface

interface gcpid_rsp_if;
   import gcpid_pkg::*;
   logic                valid;
   logic                ready;
   logic [ID_W-1:0]     point_index;
   logic [CORNER_W-1:0] corner;
   logic [STATUS_W-1:0] status;
   logic                last;
   modport source (output valid, output point_index, output corner, output status,
                   output last, input ready);
   modport sink (input valid, input point_index, input corner, input status,
                 input last, output ready);
endinterface

interface gcpid_csr_if;
   import gcpid_pkg::*;
   logic                 valid;
   logic                 ready;
   logic [CSR_IDX_W-1:0] index;
   logic [REG_W-1:0]     data;
   modport source (output valid, output index, output data, input ready);
   modport sink (input valid, input index, input data, output ready);
endinterface

[hdl/gcpid_cfg.sv]
// Extent registers and the grid geometry derived from them over three stages.
// Depends on gcpid_pkg, gcpid_if and assert_macros.svh.
`include "assert_macros.svh"
module gcpid_cfg (
   input  logic             clock,
   input  logic             reset,
   gcpid_csr_if.sink        csr,
   output gcpid_pkg::cfg_type cfg,
   output logic             hold
);
   import gcpid_pkg::*;

   localparam int WID_W = REG_W + 2;
   localparam logic [WID_W-1:0] WIDTH_LIMIT = WID_W'((64'd1 << AXIS_BITS) - 64'd1);

   logic [REG_W-1:0]    lo_ff [3];
   logic [REG_W-1:0]    hi_ff [3];
   logic [REG_W-1:0]    lo_in [3];
   logic [REG_W-1:0]    hi_in [3];
   logic [SETTLE_W-1:0] settle_ff;
   logic [SETTLE_W-1:0] settle_in;

   logic [WID_W-1:0]    wid [3];
   logic [2:0]          empty;
   logic [2:0]          wide;

   logic [STATUS_W-1:0] err_s1_ff,  err_s1_in;
   logic [DIM_W-1:0]    dim_s1_ff  [3];
   logic [DIM_W-1:0]    dim_s1_in  [3];
   logic [DIM_W-1:0]    cdim_s1_ff [3];
   logic [DIM_W-1:0]    cdim_s1_in [3];
   logic [2:0]          act_s1_ff,  act_s1_in;

   logic [STATUS_W-1:0] err_s2_ff;
   logic [2:0]          act_s2_ff;
   logic [DIM_W-1:0]    dimx_s2_ff;
   logic [DIM_W-1:0]    cdimx_s2_ff;
   logic [DIM_W-1:0]    cdimz_s2_ff;
   logic [PLANE_W-1:0]  plane_s2_ff, plane_s2_in;
   logic [PLANE_W-1:0]  pplane_s2_ff, pplane_s2_in;

   cfg_type             cfg_ff, cfg_in;
   logic [1:0]          nact;
   logic                rank_y;
   logic [1:0]          rank_z;
   logic [CORNER_W-1:0] code;
   logic                take_x, take_y, take_z;

   assign csr.ready = 1'b1;
   assign cfg       = cfg_ff;
   // Inputs wait while a write is offered and until the derived values settle.
   assign hold      = (settle_ff != '0) || csr.valid;

   always_comb begin
      lo_in = lo_ff;
      hi_in = hi_ff;
      if (csr.valid) begin
         case (csr.index)
            REG_X_LOW:  lo_in[0] = csr.data;
            REG_X_HIGH: hi_in[0] = csr.data;
            REG_Y_LOW:  lo_in[1] = csr.data;
            REG_Y_HIGH: hi_in[1] = csr.data;
            REG_Z_LOW:  lo_in[2] = csr.data;
            REG_Z_HIGH: hi_in[2] = csr.data;
            default: ;
         endcase
      end
   end

   always_comb begin
      if (csr.valid) begin
         settle_in = SETTLE_CYCLES;
      end else if (settle_ff != '0) begin
         settle_in = settle_ff - 1'b1;
      end else begin
         settle_in = settle_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int a = 0; a < 3; a++) begin
            lo_ff[a] <= '0;
            hi_ff[a] <= '1;
         end
         settle_ff <= SETTLE_CYCLES;
      end else begin
         lo_ff     <= lo_in;
         hi_ff     <= hi_in;
         settle_ff <= settle_in;
      end
   end

   // Stage 1: point counts per axis and the extent check, x before y before z.
   always_comb begin
      err_s1_in = ST_OK;
      for (int a = 0; a < 3; a++) begin
         wid[a] = {{2{hi_ff[a][REG_W-1]}}, hi_ff[a]}
                - {{2{lo_ff[a][REG_W-1]}}, lo_ff[a]} + WID_W'(1);
         empty[a]      = $signed(hi_ff[a]) < $signed(lo_ff[a]);
         wide[a]       = wid[a] > WIDTH_LIMIT;
         dim_s1_in[a]  = wid[a][DIM_W-1:0];
         act_s1_in[a]  = dim_s1_in[a] > DIM_W'(1);
         cdim_s1_in[a] = act_s1_in[a] ? dim_s1_in[a] - DIM_W'(1) : DIM_W'(1);
      end
      for (int a = 2; a >= 0; a--) begin
         if (empty[a]) begin
            err_s1_in = ST_INVALID;
         end else if (wide[a]) begin
            err_s1_in = ST_OVERFLOW;
         end
      end
   end

   // Stage 2: cell plane and point plane sizes.
   assign plane_s2_in  = PLANE_W'(cdim_s1_ff[0]) * PLANE_W'(cdim_s1_ff[1]);
   assign pplane_s2_in = PLANE_W'(dim_s1_ff[0]) * PLANE_W'(dim_s1_ff[1]);

   // Stage 3: cell count and the point id step of every corner position.
   always_comb begin
      nact   = 2'(act_s2_ff[0]) + 2'(act_s2_ff[1]) + 2'(act_s2_ff[2]);
      rank_y = act_s2_ff[0];
      rank_z = 2'(act_s2_ff[0]) + 2'(act_s2_ff[1]);
      code   = '0;
      take_x = 1'b0;
      take_y = 1'b0;
      take_z = 1'b0;
      cfg_in.err         = err_s2_ff;
      cfg_in.dim0        = dimx_s2_ff;
      cfg_in.cdim0       = cdimx_s2_ff;
      cfg_in.plane       = plane_s2_ff;
      cfg_in.pplane      = pplane_s2_ff;
      cfg_in.cells       = CELLS_W'(plane_s2_ff) * CELLS_W'(cdimz_s2_ff);
      cfg_in.last_corner = CORNER_W'((4'd1 << nact) - 4'd1);
      for (int p = 0; p < NCORNER; p++) begin
         if (nact == 2'd2) begin
            code = CYC2[p[1:0]];
         end else if (nact == 2'd3) begin
            code = CYC3[p];
         end else begin
            code = CORNER_W'(p);
         end
         // Bit b of the code steps along the b-th active axis.
         take_x = act_s2_ff[0] && code[0];
         take_y = act_s2_ff[1] && code[rank_y];
         take_z = act_s2_ff[2] && code[rank_z];
         cfg_in.delta[p] = DELTA_W'(take_x)
                         + (take_y ? DELTA_W'(dimx_s2_ff) : '0)
                         + (take_z ? DELTA_W'(pplane_s2_ff) : '0);
      end
   end

   always_ff @(posedge clock) begin
      err_s1_ff    <= err_s1_in;
      dim_s1_ff    <= dim_s1_in;
      cdim_s1_ff   <= cdim_s1_in;
      act_s1_ff    <= act_s1_in;
      err_s2_ff    <= err_s1_ff;
      act_s2_ff    <= act_s1_ff;
      dimx_s2_ff   <= dim_s1_ff[0];
      cdimx_s2_ff  <= cdim_s1_ff[0];
      cdimz_s2_ff  <= cdim_s1_ff[2];
      plane_s2_ff  <= plane_s2_in;
      pplane_s2_ff <= pplane_s2_in;
      cfg_ff       <= cfg_in;
   end

   `ASSERT_NEXT_CYCLE(a_write_holds_input, clock, reset, csr.valid && csr.ready, hold)

endmodule

[hdl/gcpid_front.sv]
// Front end: accepts cell ids, classifies them and splits each one into cell
// ijk with two pipelined restoring dividers. Depends on gcpid_pkg and gcpid_if.
module gcpid_front (
   input  logic                clock,
   input  logic                reset,
   gcpid_req_if.sink           req,
   input  gcpid_pkg::cfg_type  cfg,
   input  logic                hold,
   input  logic                q_full,
   output logic                q_push,
   output gcpid_pkg::qent_type q_data
);
   import gcpid_pkg::*;

   logic                adv;
   logic                accept;
   logic [STATUS_W-1:0] st_in;

   logic                zv_ff   [0:DIM_W];
   logic [STATUS_W-1:0] zst_ff  [0:DIM_W];
   logic [DIV_W-1:0]    zrem_ff [0:DIM_W];
   logic [DIM_W-1:0]    zq_ff   [0:DIM_W];
   logic [DIV_W-1:0]    zrem_in [0:DIM_W-1];
   logic [DIM_W-1:0]    zq_in   [0:DIM_W-1];

   logic                yv_ff   [0:DIM_W];
   logic [STATUS_W-1:0] yst_ff  [0:DIM_W];
   logic [PLANE_W-1:0]  yrem_ff [0:DIM_W];
   logic [DIM_W-1:0]    yq_ff   [0:DIM_W];
   logic [DIM_W-1:0]    yqz_ff  [0:DIM_W];
   logic [PLANE_W-1:0]  yrem_in [0:DIM_W-1];
   logic [DIM_W-1:0]    yq_in   [0:DIM_W-1];

   logic                mv_ff;
   logic [STATUS_W-1:0] mst_ff;
   logic [CELLS_W-1:0]  ma_ff, ma_in;
   logic [PLANE_W-1:0]  mb_ff, mb_in;
   logic [DIM_W-1:0]    mx_ff;

   logic                sv_ff;
   logic [STATUS_W-1:0] sst_ff;
   logic [CELLS_W-1:0]  sbase_ff, sbase_in;

   // The whole pipeline stalls only when its last stage cannot enter the queue.
   assign adv       = !(sv_ff && q_full);
   assign req.ready = adv && !hold;
   assign accept    = req.valid && req.ready;

   always_comb begin
      if (cfg.err != ST_OK) begin
         st_in = cfg.err;
      end else if (DIV_W'(req.cell_index) >= DIV_W'(cfg.cells)) begin
         st_in = ST_INVALID;
      end else begin
         st_in = ST_OK;
      end
   end

   // z = id / (cells per plane), one quotient bit per stage, msb first.
   for (genvar k = 0; k < DIM_W; k++) begin : g_zstep
      localparam int SH = DIM_W - 1 - k;
      logic [DIV_W-1:0] trial;
      logic             fits;
      assign trial      = DIV_W'(cfg.plane) << SH;
      assign fits       = zrem_ff[k] >= trial;
      assign zrem_in[k] = fits ? zrem_ff[k] - trial : zrem_ff[k];
      assign zq_in[k]   = fits ? (zq_ff[k] | (DIM_W'(1) << SH)) : zq_ff[k];
   end

   // y = remainder / (cells per row); the final remainder is x.
   for (genvar k = 0; k < DIM_W; k++) begin : g_ystep
      localparam int SH = DIM_W - 1 - k;
      logic [PLANE_W-1:0] trial;
      logic               fits;
      assign trial      = PLANE_W'(cfg.cdim0) << SH;
      assign fits       = yrem_ff[k] >= trial;
      assign yrem_in[k] = fits ? yrem_ff[k] - trial : yrem_ff[k];
      assign yq_in[k]   = fits ? (yq_ff[k] | (DIM_W'(1) << SH)) : yq_ff[k];
   end

   assign ma_in    = CELLS_W'(yqz_ff[DIM_W]) * CELLS_W'(cfg.pplane);
   assign mb_in    = PLANE_W'(yq_ff[DIM_W]) * PLANE_W'(cfg.dim0);
   assign sbase_in = ma_ff + CELLS_W'(mb_ff) + CELLS_W'(mx_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k <= DIM_W; k++) begin
            zv_ff[k] <= 1'b0;
            yv_ff[k] <= 1'b0;
         end
         mv_ff <= 1'b0;
         sv_ff <= 1'b0;
      end else if (adv) begin
         zv_ff[0] <= accept;
         for (int k = 0; k < DIM_W; k++) begin
            zv_ff[k+1] <= zv_ff[k];
            yv_ff[k+1] <= yv_ff[k];
         end
         yv_ff[0] <= zv_ff[DIM_W];
         mv_ff    <= yv_ff[DIM_W];
         sv_ff    <= mv_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         zst_ff[0]  <= st_in;
         zrem_ff[0] <= DIV_W'(req.cell_index);
         zq_ff[0]   <= '0;
         for (int k = 0; k < DIM_W; k++) begin
            zst_ff[k+1]  <= zst_ff[k];
            zrem_ff[k+1] <= zrem_in[k];
            zq_ff[k+1]   <= zq_in[k];
            yst_ff[k+1]  <= yst_ff[k];
            yrem_ff[k+1] <= yrem_in[k];
            yq_ff[k+1]   <= yq_in[k];
            yqz_ff[k+1]  <= yqz_ff[k];
         end
         yst_ff[0]  <= zst_ff[DIM_W];
         yrem_ff[0] <= zrem_ff[DIM_W][PLANE_W-1:0];
         yq_ff[0]   <= '0;
         yqz_ff[0]  <= zq_ff[DIM_W];
         mst_ff     <= yst_ff[DIM_W];
         ma_ff      <= ma_in;
         mb_ff      <= mb_in;
         mx_ff      <= yrem_ff[DIM_W][DIM_W-1:0];
         sst_ff     <= mst_ff;
         sbase_ff   <= sbase_in;
      end
   end

   assign q_push        = sv_ff && !q_full;
   assign q_data.status = sst_ff;
   assign q_data.base   = sbase_ff;

endmodule

[hdl/gcpid_queue.sv]
// Short queue between the divider front end and the corner emitter.
// Depends on gcpid_pkg and assert_macros.svh.
`include "assert_macros.svh"
module gcpid_queue (
   input  logic                clock,
   input  logic                reset,
   input  logic                push,
   input  gcpid_pkg::qent_type wdata,
   output logic                full,
   input  logic                pop,
   output logic                empty,
   output gcpid_pkg::qent_type rdata
);
   import gcpid_pkg::*;

   qent_type          ent_ff [QDEPTH];
   logic [QPTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0] count_ff, count_in;

   assign full  = count_ff == QCNT_W'(QDEPTH);
   assign empty = count_ff == '0;
   assign rdata = ent_ff[rd_ptr_ff];

   assign wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
   assign rd_ptr_in = pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
   assign count_in  = count_ff + QCNT_W'(push) - QCNT_W'(pop);

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         ent_ff[wr_ptr_ff] <= wdata;
      end
   end

   `ASSERT_SAME_CYCLE(a_no_push_when_full, clock, reset, push, !full)
   `ASSERT_SAME_CYCLE(a_no_pop_when_empty, clock, reset, pop, !empty)

endmodule

[hdl/gcpid_back.sv]
// Back end: walks the corners of the cell at the queue head and drives the
// response register, one beat per cycle while the queue is not empty and the
// sink takes each beat. Depends on gcpid_pkg, gcpid_if and assert_macros.svh.
`include "assert_macros.svh"
module gcpid_back (
   input  logic                clock,
   input  logic                reset,
   input  gcpid_pkg::cfg_type  cfg,
   input  logic                q_empty,
   input  gcpid_pkg::qent_type head,
   output logic                q_pop,
   gcpid_rsp_if.source         rsp
);
   import gcpid_pkg::*;

   logic [CORNER_W-1:0] p_ff, p_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic [ID_W-1:0]     rsp_point_ff;
   logic [CORNER_W-1:0] rsp_corner_ff;
   logic [STATUS_W-1:0] rsp_status_ff;
   logic                rsp_last_ff;

   logic                emit;
   logic                ok;
   logic                is_last;
   logic [PID_W-1:0]    pid;

   assign emit    = !q_empty && (!rsp_valid_ff || rsp.ready);
   assign ok      = head.status == ST_OK;
   // A rejected cell produces a single beat.
   assign is_last = !ok || (p_ff == cfg.last_corner);
   assign q_pop   = emit && is_last;
   assign pid     = PID_W'(head.base) + PID_W'(cfg.delta[p_ff]);

   assign p_in = emit ? (is_last ? '0 : p_ff + 1'b1) : p_ff;

   always_comb begin
      if (emit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp.ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         p_ff         <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         p_ff         <= p_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (emit) begin
         rsp_point_ff  <= ok ? pid[ID_W-1:0] : '0;
         rsp_corner_ff <= ok ? p_ff : '0;
         rsp_status_ff <= head.status;
         rsp_last_ff   <= is_last;
      end
   end

   assign rsp.valid       = rsp_valid_ff;
   assign rsp.point_index = rsp_point_ff;
   assign rsp.corner      = rsp_corner_ff;
   assign rsp.status      = rsp_status_ff;
   assign rsp.last        = rsp_last_ff;

   `ASSERT_SAME_CYCLE(a_last_ok_corner, clock, reset, rsp_valid_ff && rsp_last_ff && (rsp_status_ff == ST_OK), rsp_corner_ff == cfg.last_corner)
   `ASSERT_SAME_CYCLE(a_error_single_beat, clock, reset, rsp_valid_ff && (rsp_status_ff != ST_OK), rsp_last_ff && (rsp_corner_ff == '0) && (rsp_point_ff == '0))

endmodule

[hdl/grid_cell_corner_point_ids.sv]
// Structured grid cell to corner point ids. Six extent registers set the grid;
// each request beat carries a linear cell id and yields one response beat per
// corner (1, 2, 4 or 8 by the number of axes with more than one point), in
// cyclic order with last set on the final one, or a single beat with an error
// status. The corner emitter gives one response beat per cycle while the sink
// takes them, one beat per corner or one for a rejected cell; new cells keep
// entering while earlier ones are emitted. The first response beat of a cell
// follows the two 16-step divider pipelines, the multiply and sum registers,
// the queue and the response register. After a register write, requests are
// held off from the write cycle until the derived geometry settles. Depends on
// gcpid_pkg, gcpid_if, gcpid_cfg, gcpid_front, gcpid_queue and gcpid_back.
module grid_cell_corner_point_ids (
   input  logic       clock,
   input  logic       reset,
   gcpid_csr_if.sink  csr_if,
   gcpid_req_if.sink  req_if,
   gcpid_rsp_if.source rsp_if
);
   import gcpid_pkg::*;

   cfg_type  cfg;
   logic     hold;
   logic     q_full;
   logic     q_empty;
   logic     q_push;
   logic     q_pop;
   qent_type q_wdata;
   qent_type q_rdata;

   gcpid_cfg u_cfg (
      .clock (clock),
      .reset (reset),
      .csr   (csr_if),
      .cfg   (cfg),
      .hold  (hold)
   );

   gcpid_front u_front (
      .clock  (clock),
      .reset  (reset),
      .req    (req_if),
      .cfg    (cfg),
      .hold   (hold),
      .q_full (q_full),
      .q_push (q_push),
      .q_data (q_wdata)
   );

   gcpid_queue u_queue (
      .clock (clock),
      .reset (reset),
      .push  (q_push),
      .wdata (q_wdata),
      .full  (q_full),
      .pop   (q_pop),
      .empty (q_empty),
      .rdata (q_rdata)
   );

   gcpid_back u_back (
      .clock   (clock),
      .reset   (reset),
      .cfg     (cfg),
      .q_empty (q_empty),
      .head    (q_rdata),
      .q_pop   (q_pop),
      .rsp     (rsp_if)
   );

endmodule
